[src/ffbm_pkg.sv]
// ----------------------------------------------------------------------------
// ffbm_pkg
// Shared sizes, types and codes for the first-fit bin allocator.
// ----------------------------------------------------------------------------
package ffbm_pkg;

	localparam int MAX_BINS  = 1024;
	localparam int BLOCK_LEN = 32;
	localparam int NBLOCKS   = (MAX_BINS + BLOCK_LEN - 1) / BLOCK_LEN;

	localparam int SLOT_W = 10;
	localparam int AMT_W  = 32;
	localparam int CNT_W  = 16;
	localparam int CFG_W  = 11;
	localparam int N_W    = $clog2(MAX_BINS + 1);
	localparam int OFF_W  = $clog2(BLOCK_LEN);
	localparam int BLK_W  = (NBLOCKS > 1) ? $clog2(NBLOCKS) : 1;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [CFG_W-1:0] BIN_COUNT_RST = CFG_W'(1024);
	localparam logic [CNT_W-1:0] CNT_MAX       = '1;

	// register select taken from paddr[2]
	localparam logic REG_BIN_COUNT = 1'b0;

	// operation codes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_PLACE = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_BLOCK,
		ST_WALK,
		ST_WB,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic cap_in;
		logic load_do;
		logic walk_start;
		logic walk_step;
		logic wb_do;
		logic blk_next;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic blk_fit;
		logic blk_last;
		logic walk_done;
		logic placed;
		logic out_free;
	} sts_t;

endpackage

[src/ffbm_ctrl.sv]
// ----------------------------------------------------------------------------
// ffbm_ctrl
// Sequencer: clearing pass, load, block scan, slot walk, result hand-off.
// ----------------------------------------------------------------------------
module ffbm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_op,
	output logic            in_ready,
	input  ffbm_pkg::sts_t  sts,
	output ffbm_pkg::cmd_t  cmd
);

	ffbm_pkg::state_t state_q;
	ffbm_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffbm_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ffbm_pkg::ST_CLEAR: begin
				if (sts.clr_last) state_nxt = ffbm_pkg::ST_IDLE;
			end
			ffbm_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = (in_op == ffbm_pkg::OP_PLACE) ? ffbm_pkg::ST_BLOCK
					                                          : ffbm_pkg::ST_LOAD;
				end
			end
			ffbm_pkg::ST_LOAD: begin
				state_nxt = ffbm_pkg::ST_DONE;
			end
			ffbm_pkg::ST_BLOCK: begin
				if (sts.blk_fit) state_nxt = ffbm_pkg::ST_WALK;
				else if (sts.blk_last) state_nxt = ffbm_pkg::ST_DONE;
			end
			ffbm_pkg::ST_WALK: begin
				if (sts.walk_done) state_nxt = ffbm_pkg::ST_WB;
			end
			ffbm_pkg::ST_WB: begin
				state_nxt = (sts.placed || sts.blk_last) ? ffbm_pkg::ST_DONE
				                                          : ffbm_pkg::ST_BLOCK;
			end
			ffbm_pkg::ST_DONE: begin
				if (sts.out_free) state_nxt = ffbm_pkg::ST_IDLE;
			end
			default: state_nxt = ffbm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ffbm_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
			ffbm_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.cap_in = in_valid;
			end
			ffbm_pkg::ST_LOAD: cmd.load_do = 1'b1;
			ffbm_pkg::ST_BLOCK: begin
				cmd.walk_start = sts.blk_fit;
				cmd.blk_next   = !sts.blk_fit && !sts.blk_last;
			end
			ffbm_pkg::ST_WALK: cmd.walk_step = 1'b1;
			ffbm_pkg::ST_WB: begin
				cmd.wb_do    = 1'b1;
				cmd.blk_next = !sts.placed && !sts.blk_last;
			end
			ffbm_pkg::ST_DONE: cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

[src/ffbm_dp.sv]
// ----------------------------------------------------------------------------
// ffbm_dp
// Capacity memory, block maxima, walk pipeline and result registers.
// ----------------------------------------------------------------------------
module ffbm_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ffbm_pkg::cmd_t               cmd,
	output ffbm_pkg::sts_t               sts,
	input  logic [ffbm_pkg::N_W-1:0]     n_bins,
	input  logic                         in_op,
	input  logic [ffbm_pkg::SLOT_W-1:0]  in_slot,
	input  logic [ffbm_pkg::AMT_W-1:0]   in_amount,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         out_placed,
	output logic [ffbm_pkg::SLOT_W-1:0]  out_chosen,
	output logic [ffbm_pkg::CNT_W-1:0]   out_unplaced
);

	logic [ffbm_pkg::AMT_W-1:0]  mem [ffbm_pkg::MAX_BINS];
	logic [ffbm_pkg::AMT_W-1:0]  bmax_q [ffbm_pkg::NBLOCKS];

	logic                         op_q;
	logic [ffbm_pkg::SLOT_W-1:0]  slot_q;
	logic [ffbm_pkg::AMT_W-1:0]   amount_q;
	logic [ffbm_pkg::BLK_W-1:0]   blk_q;
	logic [ffbm_pkg::OFF_W-1:0]   off_q;
	logic                         iss_act_q;
	logic                         rd_valid_s1;
	logic [ffbm_pkg::SLOT_W-1:0]  rd_idx_s1;
	logic [ffbm_pkg::AMT_W-1:0]   rdata_s1;
	logic [ffbm_pkg::AMT_W-1:0]   max_q;
	logic                         placed_q;
	logic [ffbm_pkg::SLOT_W-1:0]  chosen_q;
	logic [ffbm_pkg::SLOT_W-1:0]  clr_q;
	logic [ffbm_pkg::CNT_W-1:0]   cnt_q;
	logic                         out_valid_q;
	logic                         out_placed_q;
	logic [ffbm_pkg::SLOT_W-1:0]  out_chosen_q;

	logic [ffbm_pkg::SLOT_W-1:0]  walk_idx;
	logic                         idx_ok;
	logic                         issue;
	logic                         slot_ok;
	logic [ffbm_pkg::BLK_W-1:0]   load_blk;
	logic [ffbm_pkg::BLK_W-1:0]   bmax_addr;
	logic [ffbm_pkg::AMT_W-1:0]   bmax_rd;
	logic                         hit;
	logic [ffbm_pkg::AMT_W-1:0]   cap_eff;
	logic                         we;
	logic [ffbm_pkg::SLOT_W-1:0]  waddr;
	logic [ffbm_pkg::AMT_W-1:0]   wdata;

	assign walk_idx = ffbm_pkg::SLOT_W'(blk_q) * ffbm_pkg::SLOT_W'(ffbm_pkg::BLOCK_LEN)
	                + ffbm_pkg::SLOT_W'(off_q);
	assign idx_ok   = ffbm_pkg::N_W'(walk_idx) < n_bins;
	assign issue    = cmd.walk_step && iss_act_q && idx_ok;
	assign slot_ok  = ffbm_pkg::N_W'(slot_q) < n_bins;
	assign load_blk = ffbm_pkg::BLK_W'(slot_q / ffbm_pkg::BLOCK_LEN);

	// one read address into the block maxima: the load's block or the scan pointer
	assign bmax_addr = cmd.load_do ? load_blk : blk_q;
	assign bmax_rd   = bmax_q[bmax_addr];

	assign hit     = rd_valid_s1 && !placed_q && (rdata_s1 >= amount_q);
	assign cap_eff = hit ? '0 : rdata_s1;

	always_comb begin
		we    = 1'b0;
		waddr = rd_idx_s1;
		wdata = '0;
		if (cmd.clr_step) begin
			we    = 1'b1;
			waddr = clr_q;
		end else if (cmd.load_do) begin
			we    = slot_ok;
			waddr = slot_q;
			wdata = amount_q;
		end else if (hit) begin
			we    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (issue) rdata_s1 <= mem[walk_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ffbm_pkg::NBLOCKS; i++) bmax_q[i] <= '0;
		end else if (cmd.wb_do) begin
			bmax_q[bmax_addr] <= max_q;
		end else if (cmd.load_do && slot_ok && (amount_q > bmax_rd)) begin
			bmax_q[bmax_addr] <= amount_q;
		end
	end

	// payload of the current transaction, walk offset, running block maximum and read index
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			op_q     <= in_op;
			slot_q   <= in_slot;
			amount_q <= in_amount;
		end
		if (cmd.walk_start) begin
			off_q <= '0;
			max_q <= '0;
		end else if (issue) begin
			off_q <= off_q + 1'b1;
		end
		if (rd_valid_s1 && !cmd.walk_start && (cap_eff > max_q)) max_q <= cap_eff;
		if (issue) rd_idx_s1 <= walk_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			blk_q       <= '0;
			iss_act_q   <= 1'b0;
			rd_valid_s1 <= 1'b0;
			placed_q    <= 1'b0;
			chosen_q    <= '0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.cap_in) begin
				blk_q    <= '0;
				placed_q <= 1'b0;
				chosen_q <= '0;
			end else if (cmd.blk_next) begin
				blk_q <= blk_q + 1'b1;
			end
			if (hit) begin
				placed_q <= 1'b1;
				chosen_q <= rd_idx_s1;
			end
			// stop issuing at the block end or past the bins in use
			if (cmd.walk_start) begin
				iss_act_q <= 1'b1;
			end else if (cmd.walk_step && iss_act_q) begin
				if (!idx_ok || (off_q == ffbm_pkg::OFF_W'(ffbm_pkg::BLOCK_LEN - 1)))
					iss_act_q <= 1'b0;
			end
			rd_valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
			if ((op_q == ffbm_pkg::OP_PLACE) && !placed_q && (cnt_q != ffbm_pkg::CNT_MAX))
				cnt_q <= cnt_q + 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_placed_q <= placed_q;
			out_chosen_q <= chosen_q;
		end
	end

	assign sts.clr_last  = clr_q == ffbm_pkg::SLOT_W'(ffbm_pkg::MAX_BINS - 1);
	assign sts.blk_fit   = bmax_rd >= amount_q;
	assign sts.blk_last  = blk_q == ffbm_pkg::BLK_W'(ffbm_pkg::NBLOCKS - 1);
	assign sts.walk_done = !iss_act_q && !rd_valid_s1;
	assign sts.placed    = placed_q;
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign out_placed   = out_placed_q;
	assign out_chosen   = out_chosen_q;
	assign out_unplaced = cnt_q;

endmodule

[src/first_fit_bin_block_max.sv]
// ----------------------------------------------------------------------------
// first_fit_bin_block_max
// First-fit single-use bin allocator with one maximum kept per block of bins.
// ----------------------------------------------------------------------------
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------
//  in      | in_valid / in_ready        | operation, slot, amount
//  out     | out_valid / out_ready      | placed, chosen_slot, unplaced_total
//  cfg     | psel, penable, pwrite, ... | bin_count at paddr 0
//
//  A load transaction goes through accept, memory write and result.
//  A place transaction is accepted, checks one block maximum at a time and
//  walks each block whose maximum fits (one capacity read a cycle through the
//  single read port of the capacity memory, then the maximum writeback) until
//  a bin is taken or the last block is passed, then hands off its result.
//  After reset a clearing pass writes zero to all 1024 capacity entries, one a
//  cycle; in_ready stays low until the pass ends. Configuration is taken
//  throughout.
//  A held result does not block the next accept; a finished item waits in the
//  result hand-off only while the output register is still occupied.
//
module first_fit_bin_block_max (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [ffbm_pkg::ADDR_W-1:0]        paddr,
	input  logic [ffbm_pkg::DATA_W-1:0]        pwdata,
	output logic [ffbm_pkg::DATA_W-1:0]        prdata,
	output logic                               pready,
	// input channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               operation,
	input  logic [ffbm_pkg::SLOT_W-1:0]        slot,
	input  logic [ffbm_pkg::AMT_W-1:0]         amount,
	// output channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               placed,
	output logic [ffbm_pkg::SLOT_W-1:0]        chosen_slot,
	output logic [ffbm_pkg::CNT_W-1:0]         unplaced_total
);

	ffbm_pkg::cmd_t              cmd;
	ffbm_pkg::sts_t              sts;
	logic [ffbm_pkg::CFG_W-1:0]  bin_count_q;
	logic [ffbm_pkg::N_W-1:0]    n_bins;
	logic                        cfg_wr;

	// Register write completes on the access phase; pready is tied high.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == ffbm_pkg::REG_BIN_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q <= ffbm_pkg::BIN_COUNT_RST;
		end else if (cfg_wr) begin
			bin_count_q <= pwdata[ffbm_pkg::CFG_W-1:0];
		end
	end

	// Return the register on reads; unmapped addresses read zero.
	assign prdata = (paddr[2] == ffbm_pkg::REG_BIN_COUNT)
	              ? ffbm_pkg::DATA_W'(bin_count_q) : '0;

	// Clamp the bin count to the slots that exist.
	assign n_bins = (bin_count_q > ffbm_pkg::CFG_W'(ffbm_pkg::MAX_BINS))
	              ? ffbm_pkg::N_W'(ffbm_pkg::MAX_BINS)
	              : ffbm_pkg::N_W'(bin_count_q);

	ffbm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (operation),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffbm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.n_bins       (n_bins),
		.in_op        (operation),
		.in_slot      (slot),
		.in_amount    (amount),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_placed   (placed),
		.out_chosen   (chosen_slot),
		.out_unplaced (unplaced_total)
	);

endmodule

[src/ffbm_chk.sv]
// ----------------------------------------------------------------------------
// ffbm_chk
// Port-level checks for the first-fit bin allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffbm_chk (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic                         placed,
	input  logic [ffbm_pkg::SLOT_W-1:0]  chosen_slot,
	input  logic [ffbm_pkg::CNT_W-1:0]   unplaced_total
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(placed)
		&& $stable(chosen_slot) && $stable(unplaced_total))
		else $error("result changed while stalled");

	// an unplaced result reports slot zero
	a_chosen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !placed |-> chosen_slot == '0)
		else $error("chosen_slot nonzero without a placement");

	// the unplaced count never goes down
	a_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> unplaced_total >= $past(unplaced_total))
		else $error("unplaced_total decreased");

	// one transaction at a time: no accept on the cycle after an accept
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted back to back");

endmodule

bind first_fit_bin_block_max ffbm_chk u_ffbm_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.placed         (placed),
	.chosen_slot    (chosen_slot),
	.unplaced_total (unplaced_total)
);

[test/first_fit_bin_block_max_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_bin_block_max_tb
// Self-checking bench for the first-fit bin allocator: a queue-fed driver and
// a monitor exchange transactions with the block while a built-in allocator
// model predicts every result. The bin count is reprogrammed between phases.
// ----------------------------------------------------------------------------
module first_fit_bin_block_max_tb;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 100;
	localparam logic [ffbm_pkg::ADDR_W-1:0] BIN_COUNT_ADDR = ffbm_pkg::ADDR_W'(0);

	typedef struct packed {
		logic                        op;
		logic [ffbm_pkg::SLOT_W-1:0] slot_idx;
		logic [ffbm_pkg::AMT_W-1:0]  size;
	} alloc_req_t;

	typedef struct packed {
		logic                        placed;
		logic [ffbm_pkg::SLOT_W-1:0] chosen;
		logic [ffbm_pkg::CNT_W-1:0]  total;
	} alloc_res_t;

	// clock, reset and block ports; every input starts at a known value
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ffbm_pkg::ADDR_W-1:0] paddr = '0;
	logic [ffbm_pkg::DATA_W-1:0] pwdata = '0;
	logic [ffbm_pkg::DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = ffbm_pkg::OP_LOAD;
	logic [ffbm_pkg::SLOT_W-1:0] slot = '0;
	logic [ffbm_pkg::AMT_W-1:0] amount = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic placed;
	logic [ffbm_pkg::SLOT_W-1:0] chosen_slot;
	logic [ffbm_pkg::CNT_W-1:0] unplaced_total;

	// allocator model state
	logic [ffbm_pkg::AMT_W-1:0] bin_cap [ffbm_pkg::MAX_BINS];
	logic [ffbm_pkg::AMT_W-1:0] blk_max [ffbm_pkg::NBLOCKS];
	logic [ffbm_pkg::CNT_W-1:0] miss_total;
	logic [ffbm_pkg::CFG_W-1:0] cfg_bin_count;

	// transaction queues and bookkeeping
	alloc_req_t pending_q[$];
	alloc_res_t expect_q[$];
	int queued_count = 0;
	int sent_count = 0;
	int errors = 0;
	int cycle_count = 0;
	int n_loads = 0;
	int n_hits = 0;
	int n_misses = 0;
	int n_cfg = 0;
	bit steady = 1'b0;
	bit hold_request = 1'b0;
	int hold_left = 0;

	always #5 clk = ~clk;

	first_fit_bin_block_max DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.slot(slot),
		.amount(amount),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.placed(placed),
		.chosen_slot(chosen_slot),
		.unplaced_total(unplaced_total)
	);

	// Apply one transaction to the allocator model and return its result.
	function automatic alloc_res_t predict_alloc(input alloc_req_t r);
		alloc_res_t res;
		int unsigned n_use, b, i, idx;
		logic [ffbm_pkg::AMT_W-1:0] blk_peak;
		res = '0;
		n_use = (cfg_bin_count < ffbm_pkg::MAX_BINS) ? cfg_bin_count : ffbm_pkg::MAX_BINS;
		if (r.op == ffbm_pkg::OP_LOAD) begin
			n_loads++;
			// loads beyond the bins in use leave all state alone
			if (r.slot_idx < n_use) begin
				bin_cap[r.slot_idx] = r.size;
				b = r.slot_idx / ffbm_pkg::BLOCK_LEN;
				// raise only; a lowered slot leaves a stale block maximum
				if (r.size > blk_max[b])
					blk_max[b] = r.size;
			end
		end else begin
			for (b = 0; b < ffbm_pkg::NBLOCKS && !res.placed; b++) begin
				if (blk_max[b] < r.size)
					continue;
				// walk the block, take the first fit, rebuild the maximum exactly
				blk_peak = '0;
				for (i = 0; i < ffbm_pkg::BLOCK_LEN; i++) begin
					idx = b * ffbm_pkg::BLOCK_LEN + i;
					if (idx >= n_use)
						break;
					if (!res.placed && bin_cap[idx] >= r.size) begin
						bin_cap[idx] = '0;
						res.placed = 1'b1;
						res.chosen = ffbm_pkg::SLOT_W'(idx);
					end
					if (bin_cap[idx] > blk_peak)
						blk_peak = bin_cap[idx];
				end
				blk_max[b] = blk_peak;
			end
			if (res.placed) begin
				n_hits++;
			end else begin
				n_misses++;
				if (miss_total != ffbm_pkg::CNT_MAX)
					miss_total++;
			end
		end
		res.total = miss_total;
		return res;
	endfunction

	function automatic bit take_break();
		return !steady && ($urandom_range(99) < 15);
	endfunction

	function automatic void push_item(input logic op, input int unsigned s,
			input logic [ffbm_pkg::AMT_W-1:0] sz);
		alloc_req_t r;
		r.op = op;
		r.slot_idx = ffbm_pkg::SLOT_W'(s);
		r.size = sz;
		pending_q.push_back(r);
		queued_count++;
	endfunction

	// Mostly loads into bins in use and modest requests, so placements keep
	// succeeding; a share of huge, tiny and out-of-range values stirs it up.
	function automatic void push_random_item();
		int unsigned n_use, pick, s;
		logic [ffbm_pkg::AMT_W-1:0] sz;
		n_use = (cfg_bin_count < ffbm_pkg::MAX_BINS) ? cfg_bin_count : ffbm_pkg::MAX_BINS;
		pick = $urandom_range(99);
		if ($urandom_range(99) < 45) begin
			if (n_use > 0 && $urandom_range(99) < 85)
				s = $urandom_range(n_use - 1);
			else
				s = $urandom_range(ffbm_pkg::MAX_BINS - 1);
			if (pick < 50)
				sz = $urandom_range(1000, 1);
			else if (pick < 80)
				sz = $urandom();
			else if (pick < 90)
				sz = '1;
			else
				sz = $urandom_range(3);
			push_item(ffbm_pkg::OP_LOAD, s, sz);
		end else begin
			if (pick < 60)
				sz = $urandom_range(1000, 1);
			else if (pick < 75)
				sz = $urandom_range(10);
			else if (pick < 90)
				sz = $urandom();
			else
				sz = '1 - ffbm_pkg::AMT_W'($urandom_range(1));
			push_item(ffbm_pkg::OP_PLACE, $urandom_range(ffbm_pkg::MAX_BINS - 1), sz);
		end
	endfunction

	// Hold until every queued transaction is accepted and answered.
	task automatic wait_drained();
		while (sent_count != queued_count || expect_q.size() != 0)
			@(negedge clk);
	endtask

	// Write the bin count, then read it back.
	task automatic write_bin_count(input logic [ffbm_pkg::DATA_W-1:0] wdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= BIN_COUNT_ADDR;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		cfg_bin_count = wdata[ffbm_pkg::CFG_W-1:0];
		n_cfg++;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[ffbm_pkg::CFG_W-1:0] !== wdata[ffbm_pkg::CFG_W-1:0]) begin
			$error("bin_count readback: expected %0d, got %0d",
				wdata[ffbm_pkg::CFG_W-1:0], prdata[ffbm_pkg::CFG_W-1:0]);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Driver: retire an accepted transaction into the model, then offer the
	// next pending item or idle. Valid is only lowered once the slot is free.
	always @(posedge clk) begin
		alloc_req_t acc;
		if (in_valid && in_ready) begin
			acc.op = operation;
			acc.slot_idx = slot;
			acc.size = amount;
			expect_q.push_back(predict_alloc(acc));
			sent_count++;
		end
		if (!in_valid || in_ready) begin
			if (arst_n && pending_q.size() > 0 && !take_break()) begin
				acc = pending_q.pop_front();
				in_valid <= 1'b1;
				operation <= acc.op;
				slot <= acc.slot_idx;
				amount <= acc.size;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: compare each result with the oldest expectation, then decide
	// ready for the next cycle. A hold request blocks the output for a long
	// stretch so the block backs up into its input.
	always @(posedge clk) begin
		alloc_res_t exp_res;
		if (out_valid && out_ready) begin
			if (expect_q.size() == 0) begin
				$error("result with nothing expected: placed %0d slot %0d total %0d",
					placed, chosen_slot, unplaced_total);
				errors++;
			end else begin
				exp_res = expect_q.pop_front();
				if (placed !== exp_res.placed) begin
					$error("placed: expected %0d, got %0d", exp_res.placed, placed);
					errors++;
				end
				if (chosen_slot !== exp_res.chosen) begin
					$error("chosen_slot: expected %0d, got %0d", exp_res.chosen,
						chosen_slot);
					errors++;
				end
				if (unplaced_total !== exp_res.total) begin
					$error("unplaced_total: expected %0d, got %0d", exp_res.total,
						unplaced_total);
					errors++;
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !take_break();
		end
	end

	// Watchdog: give up well past the slowest legal run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		for (int k = 0; k < ffbm_pkg::MAX_BINS; k++)
			bin_cap[k] = '0;
		for (int k = 0; k < ffbm_pkg::NBLOCKS; k++)
			blk_max[k] = '0;
		miss_total = '0;
		cfg_bin_count = ffbm_pkg::BIN_COUNT_RST;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, reset bin count. Empty bins: a nonzero request misses and a
		// zero request takes the first bin even at capacity zero.
		push_item(ffbm_pkg::OP_PLACE, 0, 1);
		push_item(ffbm_pkg::OP_PLACE, 0, 0);
		push_item(ffbm_pkg::OP_LOAD, 0, '1);
		push_item(ffbm_pkg::OP_LOAD, ffbm_pkg::MAX_BINS - 1, 1);
		push_item(ffbm_pkg::OP_LOAD, ffbm_pkg::BLOCK_LEN - 1, 5);
		push_item(ffbm_pkg::OP_LOAD, ffbm_pkg::BLOCK_LEN, 7);
		push_item(ffbm_pkg::OP_PLACE, 0, '1);
		push_item(ffbm_pkg::OP_PLACE, 0, 6);
		push_item(ffbm_pkg::OP_PLACE, 0, 2);
		// lower a slot so its block keeps a stale maximum, then probe past it
		push_item(ffbm_pkg::OP_LOAD, 5, 100);
		push_item(ffbm_pkg::OP_LOAD, 5, 3);
		push_item(ffbm_pkg::OP_PLACE, 0, 50);
		push_item(ffbm_pkg::OP_PLACE, ffbm_pkg::MAX_BINS - 1, 1);
		push_item(ffbm_pkg::OP_LOAD, 10'h2AA, 32'hAAAA_AAAA);
		push_item(ffbm_pkg::OP_LOAD, 10'h155, 32'h5555_5555);
		push_item(ffbm_pkg::OP_PLACE, 10'h155, 32'h5555_5556);
		push_item(ffbm_pkg::OP_PLACE, 10'h2AA, 32'h5555_5555);
		push_item(ffbm_pkg::OP_PLACE, 0, 0);

		// No bins at all: loads drop and every request misses.
		wait_drained();
		write_bin_count(0);
		push_item(ffbm_pkg::OP_LOAD, 0, 9);
		push_item(ffbm_pkg::OP_PLACE, 0, 0);
		push_item(ffbm_pkg::OP_PLACE, 0, 1);

		// A single bin: slot 1 is out of range.
		wait_drained();
		write_bin_count(1);
		push_item(ffbm_pkg::OP_LOAD, 1, 9);
		push_item(ffbm_pkg::OP_LOAD, 0, 4);
		push_item(ffbm_pkg::OP_PLACE, 0, 5);
		push_item(ffbm_pkg::OP_PLACE, 0, 4);
		push_item(ffbm_pkg::OP_PLACE, 0, 0);

		// Count above the store size, driven back to back with no idling.
		wait_drained();
		write_bin_count(2047);
		steady = 1'b1;
		repeat (80) push_random_item();
		wait_drained();
		steady = 1'b0;

		// Random count; block the output long enough to stall the input.
		write_bin_count($urandom_range(ffbm_pkg::MAX_BINS, 1));
		repeat (90) push_random_item();
		hold_request = 1'b1;

		wait_drained();
		write_bin_count(2 * ffbm_pkg::BLOCK_LEN);
		repeat (90) push_random_item();

		// Full count, written with junk above the register field.
		wait_drained();
		write_bin_count(32'hA5A5_0400);
		repeat (100) push_random_item();

		wait_drained();
		write_bin_count(1);
		repeat (30) push_random_item();

		wait_drained();
		write_bin_count($urandom_range(200, 2));
		repeat (60) push_random_item();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d transactions: %0d loads, %0d placed, %0d unplaced",
			sent_count, n_loads, n_hits, n_misses);
		$display("bin count programmed %0d times, including 0, 1, 64 and 2047", n_cfg);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
